[src/iesc_pkg.sv]
// Shared types, character codes and character classes for the expression syntax checker.
`timescale 1ns / 1ps
package iesc_pkg;

   localparam int POS_BITS_DEF = 16;
   localparam int ERR_BITS     = 16;
   localparam int BAL_BITS     = 16;
   localparam logic [BAL_BITS-1:0] BAL_MAX = '1;

   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LC_A   = 8'h61;
   localparam logic [7:0] CH_LC_Z   = 8'h7A;
   localparam logic [7:0] CH_UC_A   = 8'h41;
   localparam logic [7:0] CH_UC_Z   = 8'h5A;

   typedef struct packed {
      logic [7:0] ch;
      logic       no_char;
      logic       last;
   } req_type;

   typedef struct packed {
      logic                valid_res;
      logic [ERR_BITS-1:0] error_pos;
   } rsp_type;

   typedef enum logic [2:0] {
      MODE_START = 3'b001,
      MODE_NUM   = 3'b010,
      MODE_IDENT = 3'b100
   } mode_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
   endfunction

   function automatic logic is_holdable(input logic [7:0] c);
      return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
             (c == CH_CARET) || (c == CH_LT) || (c == CH_GT) || (c == CH_EQ);
   endfunction

endpackage

[src/iesc_in_stage.sv]
// Input register stage: holds one request transaction until the core consumes it.
`timescale 1ns / 1ps
module iesc_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iesc_pkg::req_type req_data,
   input  logic             out_free,
   output logic             item_vld,
   output iesc_pkg::req_type item,
   output logic             advance
);
   import iesc_pkg::*;

   logic    vld_ff, vld_in;
   req_type item_ff;

   // items without a result never wait on the output side
   assign advance   = vld_ff && (!item_ff.last || out_free);
   assign req_ready = !vld_ff || advance;
   assign vld_in    = (req_valid && req_ready) || (vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   assign item_vld = vld_ff;
   assign item     = item_ff;

endmodule

[src/iesc_core.sv]
// Scan state registers and the per-character syntax step.
`timescale 1ns / 1ps
module iesc_core #(
   parameter int POS_BITS = iesc_pkg::POS_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  iesc_pkg::req_type item,
   output logic              has_rsp,
   output iesc_pkg::rsp_type rsp
);
   import iesc_pkg::*;

   logic [BAL_BITS-1:0] bal_ff, bal_in;
   logic                aop_ff, aop_in;
   mode_type            mode_ff, mode_in;
   logic                dot_ff, dot_in;
   logic [7:0]          held_ff, held_in;
   logic                hv_ff, hv_in;
   logic                failed_ff, failed_in;
   logic [POS_BITS-1:0] fpos_ff, fpos_in;
   logic [POS_BITS-1:0] tpos_ff, tpos_in;
   logic [POS_BITS-1:0] cnt_ff, cnt_in;
   logic                stop;
   logic [POS_BITS-1:0] rpos;
   logic                rok;
   logic [7:0]          c;

   assign c = item.ch;

   always_comb begin
      bal_in    = bal_ff;
      aop_in    = aop_ff;
      mode_in   = mode_ff;
      dot_in    = dot_ff;
      held_in   = held_ff;
      hv_in     = hv_ff;
      failed_in = failed_ff;
      fpos_in   = fpos_ff;
      tpos_in   = tpos_ff;
      cnt_in    = cnt_ff;
      stop      = 1'b0;
      rok       = 1'b0;
      rpos      = '0;

      if (!item.no_char && !failed_ff) begin
         cnt_in = cnt_ff + POS_BITS'(1);
         if (hv_ff) begin
            hv_in = 1'b0;
            if (c == CH_EQ) begin
               // two-character comparison, counted as one position
               if (aop_ff) begin
                  failed_in = 1'b1;
                  fpos_in   = tpos_ff - POS_BITS'(1);
               end else begin
                  aop_in = 1'b1;
               end
               stop = 1'b1;
            end else if (held_ff == CH_BANG || aop_ff) begin
               failed_in = 1'b1;
               fpos_in   = tpos_ff - POS_BITS'(1);
               stop      = 1'b1;
            end else begin
               aop_in  = 1'b1;
               mode_in = MODE_START;
               dot_in  = 1'b0;
            end
         end
         if (!stop) begin
            if (is_holdable(c)) begin
               mode_in = MODE_START;
               dot_in  = 1'b0;
               held_in = c;
               hv_in   = 1'b1;
            end else if (is_digit(c) || c == CH_DOT) begin
               aop_in = 1'b0;
               if (mode_in == MODE_NUM) begin
                  if (c == CH_DOT) begin
                     if (dot_in) begin
                        failed_in = 1'b1;
                        fpos_in   = tpos_ff;
                     end else begin
                        dot_in = 1'b1;
                     end
                  end
               end else if (!(mode_in == MODE_IDENT && is_digit(c))) begin
                  mode_in = MODE_NUM;
                  dot_in  = (c == CH_DOT);
               end
            end else if (is_alpha(c) || c == CH_UNDER) begin
               aop_in  = 1'b0;
               mode_in = MODE_IDENT;
               dot_in  = 1'b0;
            end else begin
               mode_in = MODE_START;
               dot_in  = 1'b0;
               if (is_ws(c)) begin
                  // separator only
               end else if (c == CH_LPAREN) begin
                  if (bal_ff != BAL_MAX) begin
                     bal_in = bal_ff + BAL_BITS'(1);
                  end
                  aop_in = 1'b1;
               end else if (c == CH_RPAREN) begin
                  if (bal_ff == '0) begin
                     failed_in = 1'b1;
                     fpos_in   = tpos_ff;
                  end else begin
                     bal_in = bal_ff - BAL_BITS'(1);
                     aop_in = 1'b0;
                  end
               end else if (is_op(c)) begin
                  if (aop_in && c != CH_PLUS && c != CH_MINUS) begin
                     failed_in = 1'b1;
                     fpos_in   = tpos_ff;
                  end else begin
                     aop_in = 1'b1;
                  end
               end else begin
                  failed_in = 1'b1;
                  fpos_in   = tpos_ff;
               end
            end
            tpos_in = tpos_ff + POS_BITS'(1);
         end
      end

      if (item.last) begin
         // a pending comparison char at the end stands alone
         if (!failed_in && hv_in) begin
            hv_in = 1'b0;
            if (held_in == CH_BANG || aop_in) begin
               failed_in = 1'b1;
               fpos_in   = tpos_in - POS_BITS'(1);
            end else begin
               aop_in = 1'b1;
            end
         end
         if (failed_in) begin
            rpos = fpos_in;
         end else if (cnt_in == '0) begin
            rpos = '0;
         end else if (bal_in != '0 || aop_in) begin
            rpos = cnt_in - POS_BITS'(1);
         end else begin
            rok = 1'b1;
         end
         bal_in    = '0;
         aop_in    = 1'b1;
         mode_in   = MODE_START;
         dot_in    = 1'b0;
         held_in   = '0;
         hv_in     = 1'b0;
         failed_in = 1'b0;
         fpos_in   = '0;
         tpos_in   = '0;
         cnt_in    = '0;
      end
   end

   assign has_rsp       = advance && item.last;
   assign rsp.valid_res = rok;
   assign rsp.error_pos = ERR_BITS'(rpos);

   always_ff @(posedge clock) begin
      if (reset) begin
         bal_ff    <= '0;
         aop_ff    <= 1'b1;
         mode_ff   <= MODE_START;
         dot_ff    <= 1'b0;
         held_ff   <= '0;
         hv_ff     <= 1'b0;
         failed_ff <= 1'b0;
         fpos_ff   <= '0;
         tpos_ff   <= '0;
         cnt_ff    <= '0;
      end else if (advance) begin
         bal_ff    <= bal_in;
         aop_ff    <= aop_in;
         mode_ff   <= mode_in;
         dot_ff    <= dot_in;
         held_ff   <= held_in;
         hv_ff     <= hv_in;
         failed_ff <= failed_in;
         fpos_ff   <= fpos_in;
         tpos_ff   <= tpos_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[src/iesc_out_reg.sv]
// Result register: holds one response transaction until the consumer takes it.
`timescale 1ns / 1ps
module iesc_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  iesc_pkg::rsp_type load_data,
   output logic              out_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output iesc_pkg::rsp_type rsp_data
);
   import iesc_pkg::*;

   logic    vld_ff, vld_in;
   rsp_type data_ff;

   assign out_free = !vld_ff || rsp_ready;
   assign vld_in   = load || (vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

[src/infix_expression_syntax_checker_top.sv]
// End transactions pass from the input register into the result register behind rsp_valid.
// Throughput: one character per cycle unless a result stalls; one scan state step per character.
// A result stalled by rsp back pressure holds the end transaction in the input register,
// which then blocks further requests until the result is taken.
// Reset (synchronous, active high) empties both registers and returns the scan state
// to token start with no open parentheses and no error recorded.
`timescale 1ns / 1ps
module infix_expression_syntax_checker_top #(
   parameter int POS_BITS = iesc_pkg::POS_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  iesc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output iesc_pkg::rsp_type rsp_data
);
   import iesc_pkg::*;

   logic    out_free;
   logic    item_vld;
   req_type item;
   logic    advance;
   logic    has_rsp;
   rsp_type core_rsp;

   iesc_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .item_vld  (item_vld),
      .item      (item),
      .advance   (advance)
   );

   iesc_core #(
      .POS_BITS (POS_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance && item_vld),
      .item    (item),
      .has_rsp (has_rsp),
      .rsp     (core_rsp)
   );

   iesc_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (has_rsp),
      .load_data (core_rsp),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[src/iesc_checker.sv]
// Port-level checks for the expression syntax checker, bound to the top level.
`timescale 1ns / 1ps
module iesc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input iesc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input iesc_pkg::rsp_type rsp_data
);
   import iesc_pkg::*;

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // an accepted expression never carries an error position
   a_ok_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.valid_res |-> rsp_data.error_pos == '0)
      else $error("valid result with nonzero error position");

   // input only stalls behind a pending result
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a request stall always comes from a result the consumer is not taking
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without output back pressure");

endmodule

bind infix_expression_syntax_checker_top iesc_checker u_iesc_checker (.*);
